// ===== src/b64se_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared item types, the group record passed from front to back, and the
// sextet-to-character mapping of the standard alphabet.
// ----------------------------------------------------------------------------
package b64se_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [5:0] SIX_BITS = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad_cnt;
    logic        last;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] enc_char(input logic [5:0] sextet);
    logic [7:0] v;
    v = {2'b00, sextet & SIX_BITS};
    if (sextet < 6'd26) begin
      enc_char = 8'h41 + v;
    end else if (sextet < 6'd52) begin
      enc_char = 8'h61 + v - 8'd26;
    end else if (sextet < 6'd62) begin
      enc_char = 8'h30 + v - 8'd52;
    end else if (sextet == 6'd62) begin
      enc_char = 8'h2B;
    end else begin
      enc_char = 8'h2F;
    end
  endfunction

endpackage

// ===== src/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard Base64 characters with '=' padding.
//
// The input channel takes one byte per item with a flag on the final byte of
// the message. The output channel delivers one ASCII character per item, and
// the final character of a message carries last_char.
// Every third byte, or the final byte, closes a group that the front end
// pushes into a short queue; the back end turns each group into four
// characters at one character per cycle while the output is not stalled, so
// the character serializer sets the rate. A group is written into the queue
// memory when the byte that closes it is accepted, and its first character
// then reaches the output register once the back end loads it.
// Bytes are accepted in every cycle while the queue has room. When the
// receiver stalls, the output register holds its character, the queue fills
// and the input stall rises. Reset clears the pending bytes, the queue and
// the output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64se_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64se_pkg::out_item_t out_item
);

  b64se_pkg::q_push_t   q_push;
  b64se_pkg::q_status_t q_status;
  b64se_pkg::group_t    head;
  logic                 pop;

  b64se_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .q_push   (q_push)
  );

  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/b64se_front.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts message bytes, holds up to two pending bytes and pushes a complete
// or padded 24-bit group into the queue.
// ----------------------------------------------------------------------------
module b64se_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64se_pkg::in_item_t  in_item,
  input  b64se_pkg::q_status_t q_status,
  output b64se_pkg::q_push_t   q_push
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    held_nxt         = held_r;
    cnt_nxt          = cnt_r;
    q_push.valid     = 1'b0;
    q_push.grp.bits  = {held_r, in_item.data_byte};
    q_push.grp.pad_cnt = 2'd0;
    q_push.grp.last  = in_item.last_byte;
    if (cnt_r[1]) begin
      q_push.grp.bits    = {held_r, in_item.data_byte};
      q_push.grp.pad_cnt = 2'd0;
    end else if (cnt_r[0]) begin
      q_push.grp.bits    = {held_r[7:0], in_item.data_byte, 8'h00};
      q_push.grp.pad_cnt = 2'd1;
    end else begin
      q_push.grp.bits    = {in_item.data_byte, 16'h0000};
      q_push.grp.pad_cnt = 2'd2;
    end
    if (accept) begin
      if (cnt_r[1] || in_item.last_byte) begin
        q_push.valid = 1'b1;
        held_nxt     = 16'h0000;
        cnt_nxt      = 2'd0;
      end else begin
        held_nxt = {held_r[7:0], in_item.data_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/b64se_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short first-in first-out buffer of groups between front and back.
// ----------------------------------------------------------------------------
module b64se_queue #(
  parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64se_pkg::q_push_t   q_push,
  input  logic                 pop,
  output b64se_pkg::group_t    head,
  output b64se_pkg::q_status_t q_status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64se_pkg::group_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = (cnt_r == CW'(DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign head           = mem_r[rd_ptr_r];
  assign do_push        = q_push.valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/b64se_back.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Takes one group at a time from the queue and sends its four characters,
// one per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module b64se_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64se_pkg::group_t    head,
  input  b64se_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64se_pkg::out_item_t out_item
);

  logic [1:0]           idx_r, idx_nxt;
  logic                 valid_r, valid_nxt;
  b64se_pkg::out_item_t item_r, item_nxt;
  logic                 load;
  logic [5:0]           sextet;
  logic                 is_pad;

  assign load      = !q_status.empty && (!valid_r || !out_stall);
  assign pop       = load && (idx_r == 2'd3);
  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign is_pad    = ((2'd3 - idx_r) < head.pad_cnt);

  always_comb begin
    case (idx_r)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      2'd3:    sextet = head.bits[5:0];
      default: sextet = head.bits[5:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      idx_nxt            = idx_r + 2'd1;
      valid_nxt          = 1'b1;
      item_nxt.out_char  = is_pad ? b64se_pkg::PAD_CHAR : b64se_pkg::enc_char(sextet);
      item_nxt.last_char = (idx_r == 2'd3) && head.last;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== tb/base64_stream_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Feeds byte messages through the encoder under random and long receiver
// stalls and sender gaps. A local encoder predicts every character, and each
// character that leaves the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_SETTLE = 20;
  localparam int HOLD_CYCLES = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  b64se_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  b64se_pkg::out_item_t out_item;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64se_pkg::out_item_t expected_chars[$];
  b64se_pkg::out_item_t want_char;
  logic [15:0]          pend_bytes;
  int                   pend_count;
  int                   errors = 0;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  int                   stuck_cycles = 0;

  base64_stream_encoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_ascii(input logic [5:0] sextet);
    return b64_alphabet[sextet];
  endfunction

  function automatic void add_char(input logic [7:0] c, input logic lst);
    b64se_pkg::out_item_t item;
    item.out_char = c;
    item.last_char = lst;
    expected_chars.push_back(item);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    logic [23:0] grp;
    if (pend_count == 2) begin
      grp = {pend_bytes, b};
      add_char(sextet_ascii(grp[23:18]), 1'b0);
      add_char(sextet_ascii(grp[17:12]), 1'b0);
      add_char(sextet_ascii(grp[11:6]), 1'b0);
      add_char(sextet_ascii(grp[5:0]), lst);
      pend_bytes = '0;
      pend_count = 0;
    end else if (!lst) begin
      pend_bytes = {pend_bytes[7:0], b};
      pend_count = pend_count + 1;
    end else begin
      if (pend_count == 1) begin
        grp = {pend_bytes[7:0], b, 8'h00};
        add_char(sextet_ascii(grp[23:18]), 1'b0);
        add_char(sextet_ascii(grp[17:12]), 1'b0);
        add_char(sextet_ascii(grp[11:6]), 1'b0);
      end else begin
        grp = {b, 16'h0000};
        add_char(sextet_ascii(grp[23:18]), 1'b0);
        add_char(sextet_ascii(grp[17:12]), 1'b0);
        add_char(b64se_pkg::PAD_CHAR, 1'b0);
      end
      add_char(b64se_pkg::PAD_CHAR, 1'b1);
      pend_bytes = '0;
      pend_count = 0;
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item.data_byte <= b;
    in_item.last_byte <= lst;
    do @(posedge clk); while (in_stall);
    encode_byte(b, lst);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic push_random_traffic(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        push_message(len);
        sent += len;
      end else begin
        push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        sent += 1;
      end
    end
  endtask

  task automatic test_directed();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6E, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_idle(input int snd_pct, input int rcv_pct, input int n_items);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    push_random_traffic(n_items);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = hold_req + 1;
    push_random_traffic(40);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char %h last_char %b",
               out_item.out_char, out_item.last_char);
        errors++;
      end else begin
        want_char = expected_chars.pop_front();
        if (out_item.out_char !== want_char.out_char) begin
          $error("out_char mismatch: expected %h, actual %h",
                 want_char.out_char, out_item.out_char);
          errors++;
        end
        if (out_item.last_char !== want_char.last_char) begin
          $error("last_char mismatch: expected %b, actual %b",
                 want_char.last_char, out_item.last_char);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    pend_bytes = '0;
    pend_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_idle(9, 46, 100);
    test_random_idle(46, 9, 100);
    test_random_idle(0, 0, 60);
    test_backpressure();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
